// ----- rtl/blsc_pkg.sv -----
// ---------------------------------------------------------------------------
// blsc_pkg: shared types and constants for the load-shedding controller
// Band codes, configuration record, register map and reset values.
// ---------------------------------------------------------------------------
package blsc_pkg;

    localparam int unsigned SAMPLE_W   = 8;
    localparam int unsigned DUTY_W     = 8;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned REG_COUNT  = 8;
    localparam int unsigned REG_IDX_W  = $clog2(REG_COUNT);
    localparam int unsigned APB_ADDR_W = REG_IDX_W + 2;

    typedef enum logic [1:0] {
        BAND_SLEEP = 2'd0,
        BAND_CRIT  = 2'd1,
        BAND_EASE  = 2'd2,
        BAND_RAISE = 2'd3
    } band_t;

    localparam logic [REG_IDX_W-1:0] REG_RAISE_LEVEL   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_EASE_LEVEL    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SLEEP_LEVEL   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DUTY_LIMIT    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BEAT_PERIOD   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SLOW_PERIOD   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MEDIUM_PERIOD = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_FAST_PERIOD   = 3'd7;

    localparam logic [7:0] RST_RAISE_LEVEL   = 8'd133;
    localparam logic [7:0] RST_EASE_LEVEL    = 8'd128;
    localparam logic [7:0] RST_SLEEP_LEVEL   = 8'd123;
    localparam logic [7:0] RST_DUTY_LIMIT    = 8'd250;
    localparam logic [7:0] RST_BEAT_PERIOD   = 8'd10;
    localparam logic [7:0] RST_SLOW_PERIOD   = 8'd100;
    localparam logic [7:0] RST_MEDIUM_PERIOD = 8'd30;
    localparam logic [7:0] RST_FAST_PERIOD   = 8'd10;

    typedef struct packed {
        logic [7:0] raise_level;
        logic [7:0] ease_level;
        logic [7:0] sleep_level;
        logic [7:0] duty_limit;
        logic [7:0] beat_period;
        logic [7:0] slow_period;
        logic [7:0] medium_period;
        logic [7:0] fast_period;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        raise_level:   RST_RAISE_LEVEL,
        ease_level:    RST_EASE_LEVEL,
        sleep_level:   RST_SLEEP_LEVEL,
        duty_limit:    RST_DUTY_LIMIT,
        beat_period:   RST_BEAT_PERIOD,
        slow_period:   RST_SLOW_PERIOD,
        medium_period: RST_MEDIUM_PERIOD,
        fast_period:   RST_FAST_PERIOD
    };

endpackage

// ----- rtl/blsc_if.sv -----
// ---------------------------------------------------------------------------
// blsc_if: request channels of the load-shedding controller
// Sample channel (four battery readings) and result channel (duties, pins).
// ---------------------------------------------------------------------------
interface blsc_sample_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample_a;
    logic [7:0] sample_b;
    logic [7:0] sample_c;
    logic [7:0] sample_d;

    modport source (output valid, output sample_a, output sample_b,
                    output sample_c, output sample_d, input ready);
    modport sink   (input valid, input sample_a, input sample_b,
                    input sample_c, input sample_d, output ready);
endinterface

interface blsc_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty_one;
    logic [7:0] duty_two;
    logic       beat_pin;
    logic       status_pin;
    logic       slept;
    logic [1:0] band;

    modport source (output valid, output duty_one, output duty_two,
                    output beat_pin, output status_pin, output slept,
                    output band, input ready);
    modport sink   (input valid, input duty_one, input duty_two,
                    input beat_pin, input status_pin, input slept,
                    input band, output ready);
endinterface

// ----- rtl/blsc_front.sv -----
// ---------------------------------------------------------------------------
// blsc_front: sample intake and band classification
// Averages the four readings and registers the band for the queue.
// ---------------------------------------------------------------------------
module blsc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  blsc_pkg::cfg_t       cfg,
    blsc_sample_if.sink          sample_ch,
    output logic                 push_valid,
    input  logic                 push_ready,
    output blsc_pkg::band_t      push_band
);

    logic                  valid_reg;
    logic                  valid_next;
    blsc_pkg::band_t       band_reg;
    logic [9:0]            sum;
    logic [7:0]            avg;
    blsc_pkg::band_t       band_class;
    logic                  take;

    assign sample_ch.ready = !valid_reg || push_ready;
    assign take            = sample_ch.valid && sample_ch.ready;

    assign sum = {2'b00, sample_ch.sample_a} + {2'b00, sample_ch.sample_b}
               + {2'b00, sample_ch.sample_c} + {2'b00, sample_ch.sample_d};
    assign avg = sum[9:2];

    always_comb
    begin
        if (avg < cfg.sleep_level)
        begin
            band_class = blsc_pkg::BAND_SLEEP;
        end
        else if (avg > cfg.raise_level)
        begin
            band_class = blsc_pkg::BAND_RAISE;
        end
        else if (avg > cfg.ease_level)
        begin
            band_class = blsc_pkg::BAND_EASE;
        end
        else
        begin
            band_class = blsc_pkg::BAND_CRIT;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            band_reg <= band_class;
        end
    end

    assign push_valid = valid_reg;
    assign push_band  = band_reg;

endmodule

// ----- rtl/blsc_queue.sv -----
// ---------------------------------------------------------------------------
// blsc_queue: small FIFO between classification and execution
// Holds classified requests so either side can stall on its own.
// ---------------------------------------------------------------------------
module blsc_queue #(
    parameter int unsigned DEPTH = blsc_pkg::QUEUE_DEPTH_DEF,
    parameter int unsigned WIDTH = $bits(blsc_pkg::band_t)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/blsc_back.sv -----
// ---------------------------------------------------------------------------
// blsc_back: duty stepping, heartbeat and status blink
// Applies one classified request per cycle while the result is not stalled, and registers the result.
// ---------------------------------------------------------------------------
module blsc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  blsc_pkg::cfg_t   cfg,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  blsc_pkg::band_t  pop_band,
    blsc_result_if.source    result_ch
);

    logic [7:0] first_duty_reg,  first_duty_next;
    logic [7:0] second_duty_reg, second_duty_next;
    logic [7:0] beat_count_reg,  beat_count_next;
    logic [7:0] blink_count_reg, blink_count_next;
    logic       beat_level_reg,  beat_level_next;
    logic       blink_level_reg, blink_level_next;
    logic       out_valid_reg,   out_valid_next;
    logic       slept_reg;
    logic [1:0] band_reg;

    logic [7:0] period;
    logic [7:0] beat_inc;
    logic [7:0] blink_inc;
    logic [7:0] first_step;
    logic [7:0] second_step;
    logic       do_pop;

    assign pop_ready = !out_valid_reg || result_ch.ready;
    assign do_pop    = pop_valid && pop_ready;
    assign beat_inc  = beat_count_reg + 8'd1;
    assign blink_inc = blink_count_reg + 8'd1;

    always_comb
    begin
        period           = cfg.fast_period;
        first_step       = first_duty_reg;
        second_step      = second_duty_reg;
        first_duty_next  = first_duty_reg;
        second_duty_next = second_duty_reg;
        beat_count_next  = beat_count_reg;
        blink_count_next = blink_count_reg;
        beat_level_next  = beat_level_reg;
        blink_level_next = blink_level_reg;

        unique case (pop_band)
            blsc_pkg::BAND_RAISE:
            begin
                period = cfg.slow_period;
                if (first_duty_reg < cfg.duty_limit)
                begin
                    first_step = first_duty_reg + 8'd1;
                end
                else if (second_duty_reg < cfg.duty_limit)
                begin
                    second_step = second_duty_reg + 8'd1;
                end
            end
            blsc_pkg::BAND_EASE:
            begin
                period = cfg.medium_period;
                if (second_duty_reg != 8'd0)
                begin
                    second_step = second_duty_reg - 8'd1;
                end
                else if (first_duty_reg != 8'd0)
                begin
                    first_step = first_duty_reg - 8'd1;
                end
            end
            blsc_pkg::BAND_CRIT:
            begin
                period = cfg.fast_period;
                // wrap below zero is caught by the limit check unless the limit is 255
                if (second_duty_reg != 8'd0)
                begin
                    second_step = second_duty_reg - 8'd2;
                end
                else if (first_duty_reg != 8'd0)
                begin
                    first_step = first_duty_reg - 8'd2;
                end
            end
            blsc_pkg::BAND_SLEEP:
            begin
                period = cfg.fast_period;
            end
            default:
            begin
                period = cfg.fast_period;
            end
        endcase

        if (do_pop)
        begin
            if (pop_band == blsc_pkg::BAND_SLEEP)
            begin
                // drop both loads, hold the counters
                first_duty_next  = 8'd0;
                second_duty_next = 8'd0;
                beat_level_next  = 1'b1;
                blink_level_next = 1'b0;
            end
            else
            begin
                if (beat_inc >= cfg.beat_period)
                begin
                    beat_count_next = 8'd0;
                    beat_level_next = !beat_level_reg;
                end
                else
                begin
                    beat_count_next = beat_inc;
                end
                if (blink_inc >= period)
                begin
                    blink_count_next = 8'd0;
                    blink_level_next = !blink_level_reg;
                end
                else
                begin
                    blink_count_next = blink_inc;
                end
                first_duty_next  = (first_step > cfg.duty_limit) ? 8'd0 : first_step;
                second_duty_next = (second_step > cfg.duty_limit) ? 8'd0 : second_step;
            end
        end

        out_valid_next = out_valid_reg;
        if (do_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_duty_reg  <= 8'd0;
            second_duty_reg <= 8'd0;
            beat_count_reg  <= 8'd0;
            blink_count_reg <= 8'd0;
            beat_level_reg  <= 1'b0;
            blink_level_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            first_duty_reg  <= first_duty_next;
            second_duty_reg <= second_duty_next;
            beat_count_reg  <= beat_count_next;
            blink_count_reg <= blink_count_next;
            beat_level_reg  <= beat_level_next;
            blink_level_reg <= blink_level_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            slept_reg <= (pop_band == blsc_pkg::BAND_SLEEP);
            band_reg  <= pop_band;
        end
    end

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.duty_one   = first_duty_reg;
    assign result_ch.duty_two   = second_duty_reg;
    assign result_ch.beat_pin   = beat_level_reg;
    assign result_ch.status_pin = blink_level_reg;
    assign result_ch.slept      = slept_reg;
    assign result_ch.band       = band_reg;

endmodule

// ----- rtl/battery_load_shedding_controller_core.sv -----
// ---------------------------------------------------------------------------
// battery_load_shedding_controller_core: top level of the load shedder
// Per tick, averages four battery readings and steps two load duties.
// ---------------------------------------------------------------------------
// Usage:
//   sample_ch carries one tick request: four 8-bit battery readings.
//   result_ch returns one request per tick: both load duties, heartbeat and
//   status pin levels, the slept flag and the voltage band.
//   Thresholds and periods sit in eight APB registers at byte offsets 4*i;
//   write them only while no tick is in flight.
//   A tick passes the classify register, a queue slot and the duty/blink
//   update registers before its result shows on result_ch.
//   Throughput: one tick per cycle while result_ch.ready keeps up; the duty
//   and counter update is combinational, so only a stalled receiver throttles.
//   A stalled receiver holds the result register; the queue between the
//   classifier and the update stage absorbs requests until it fills, then
//   sample_ch.ready drops.
//   Reset clears duties, counters, pin levels and the queue, and loads the
//   registers with their default levels and periods.
// ---------------------------------------------------------------------------
module battery_load_shedding_controller_core #(
    parameter int unsigned QUEUE_DEPTH = blsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    blsc_sample_if.sink                       sample_ch,
    blsc_result_if.source                     result_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [blsc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [blsc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [blsc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    blsc_pkg::cfg_t                   cfg_reg, cfg_next;
    logic [blsc_pkg::REG_IDX_W-1:0]   reg_idx;
    logic [7:0]                       rd_value;
    logic                             wr_en;

    logic                             push_valid, push_ready;
    blsc_pkg::band_t                  push_band;
    logic                             pop_valid, pop_ready;
    logic [1:0]                       pop_bits;
    blsc_pkg::band_t                  pop_band;

    assign pready  = 1'b1;
    assign reg_idx = paddr[blsc_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        rd_value = 8'd0;
        unique case (reg_idx)
            blsc_pkg::REG_RAISE_LEVEL:   rd_value = cfg_reg.raise_level;
            blsc_pkg::REG_EASE_LEVEL:    rd_value = cfg_reg.ease_level;
            blsc_pkg::REG_SLEEP_LEVEL:   rd_value = cfg_reg.sleep_level;
            blsc_pkg::REG_DUTY_LIMIT:    rd_value = cfg_reg.duty_limit;
            blsc_pkg::REG_BEAT_PERIOD:   rd_value = cfg_reg.beat_period;
            blsc_pkg::REG_SLOW_PERIOD:   rd_value = cfg_reg.slow_period;
            blsc_pkg::REG_MEDIUM_PERIOD: rd_value = cfg_reg.medium_period;
            blsc_pkg::REG_FAST_PERIOD:   rd_value = cfg_reg.fast_period;
            default:                     rd_value = 8'd0;
        endcase
        if (wr_en)
        begin
            unique case (reg_idx)
                blsc_pkg::REG_RAISE_LEVEL:   cfg_next.raise_level   = pwdata[7:0];
                blsc_pkg::REG_EASE_LEVEL:    cfg_next.ease_level    = pwdata[7:0];
                blsc_pkg::REG_SLEEP_LEVEL:   cfg_next.sleep_level   = pwdata[7:0];
                blsc_pkg::REG_DUTY_LIMIT:    cfg_next.duty_limit    = pwdata[7:0];
                blsc_pkg::REG_BEAT_PERIOD:   cfg_next.beat_period   = pwdata[7:0];
                blsc_pkg::REG_SLOW_PERIOD:   cfg_next.slow_period   = pwdata[7:0];
                blsc_pkg::REG_MEDIUM_PERIOD: cfg_next.medium_period = pwdata[7:0];
                blsc_pkg::REG_FAST_PERIOD:   cfg_next.fast_period   = pwdata[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    assign prdata = {{(blsc_pkg::APB_DATA_W-8){1'b0}}, rd_value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= blsc_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    blsc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .sample_ch  (sample_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_band  (push_band)
    );

    blsc_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(blsc_pkg::band_t))
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_band),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_bits)
    );

    assign pop_band = blsc_pkg::band_t'(pop_bits);

    blsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_band  (pop_band),
        .result_ch (result_ch)
    );

endmodule

// ----- dv/battery_load_shedding_controller_core_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// battery_load_shedding_controller_core_tb: self-checking bench for the core
// Streams battery ticks through the sample channel with random gaps and
// result stalls. A local copy of the duty, heartbeat and status logic
// predicts every result, and each result is checked field by field. Between
// phases, while the pipe is empty, the APB registers are rewritten with
// extreme and random thresholds, limits and periods.
// ---------------------------------------------------------------------------
module battery_load_shedding_controller_core_tb;

    typedef struct packed {
        logic [7:0]      duty_one;
        logic [7:0]      duty_two;
        logic            beat_pin;
        logic            status_pin;
        logic            slept;
        blsc_pkg::band_t band;
    } tick_result_t;

    class duty_predictor;
        blsc_pkg::cfg_t cfg;
        logic [7:0]     first_duty;
        logic [7:0]     second_duty;
        logic [7:0]     beat_count;
        logic [7:0]     blink_count;
        logic           beat_level;
        logic           blink_level;
        tick_result_t   pending_results[$];
        int             mismatches;

        function new();
            cfg         = blsc_pkg::CFG_RESET;
            first_duty  = '0;
            second_duty = '0;
            beat_count  = '0;
            blink_count = '0;
            beat_level  = 1'b0;
            blink_level = 1'b0;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [blsc_pkg::REG_IDX_W-1:0] idx, logic [7:0] value);
            case (idx)
                blsc_pkg::REG_RAISE_LEVEL:   cfg.raise_level   = value;
                blsc_pkg::REG_EASE_LEVEL:    cfg.ease_level    = value;
                blsc_pkg::REG_SLEEP_LEVEL:   cfg.sleep_level   = value;
                blsc_pkg::REG_DUTY_LIMIT:    cfg.duty_limit    = value;
                blsc_pkg::REG_BEAT_PERIOD:   cfg.beat_period   = value;
                blsc_pkg::REG_SLOW_PERIOD:   cfg.slow_period   = value;
                blsc_pkg::REG_MEDIUM_PERIOD: cfg.medium_period = value;
                blsc_pkg::REG_FAST_PERIOD:   cfg.fast_period   = value;
                default: ;
            endcase
        endfunction

        // Advance a tick counter; report a wrap past its period.
        function bit bump(inout logic [7:0] cnt, input logic [7:0] period);
            cnt = cnt + 8'd1;
            if (cnt >= period)
            begin
                cnt = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void take_tick(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d);
            logic [9:0]   sum;
            logic [7:0]   avg;
            logic [7:0]   period;
            tick_result_t r;
            sum     = 10'(a) + 10'(b) + 10'(c) + 10'(d);
            avg     = sum[9:2];
            r.slept = 1'b0;
            if (avg < cfg.sleep_level)
            begin
                first_duty  = '0;
                second_duty = '0;
                beat_level  = 1'b1;
                blink_level = 1'b0;
                r.slept     = 1'b1;
                r.band      = blsc_pkg::BAND_SLEEP;
            end
            else
            begin
                if (avg > cfg.raise_level)
                begin
                    r.band = blsc_pkg::BAND_RAISE;
                    period = cfg.slow_period;
                end
                else if (avg > cfg.ease_level)
                begin
                    r.band = blsc_pkg::BAND_EASE;
                    period = cfg.medium_period;
                end
                else
                begin
                    r.band = blsc_pkg::BAND_CRIT;
                    period = cfg.fast_period;
                end
                if (bump(beat_count, cfg.beat_period))
                    beat_level = ~beat_level;
                if (bump(blink_count, period))
                    blink_level = ~blink_level;
                case (r.band)
                    blsc_pkg::BAND_RAISE:
                    begin
                        if (first_duty < cfg.duty_limit)
                            first_duty = first_duty + 8'd1;
                        else if (second_duty < cfg.duty_limit)
                            second_duty = second_duty + 8'd1;
                    end
                    blsc_pkg::BAND_EASE:
                    begin
                        if (second_duty != 0)
                            second_duty = second_duty - 8'd1;
                        else if (first_duty != 0)
                            first_duty = first_duty - 8'd1;
                    end
                    default:
                    begin
                        // drop by two; a wrap past zero lands above any limit below 255
                        if (second_duty != 0)
                        begin
                            second_duty = second_duty - 8'd2;
                            if (second_duty > cfg.duty_limit)
                                second_duty = '0;
                        end
                        else if (first_duty != 0)
                        begin
                            first_duty = first_duty - 8'd2;
                            if (first_duty > cfg.duty_limit)
                                first_duty = '0;
                        end
                    end
                endcase
                if (first_duty > cfg.duty_limit)
                    first_duty = '0;
                if (second_duty > cfg.duty_limit)
                    second_duty = '0;
            end
            r.duty_one   = first_duty;
            r.duty_two   = second_duty;
            r.beat_pin   = beat_level;
            r.status_pin = blink_level;
            pending_results.push_back(r);
        endfunction

        function void match_result(tick_result_t got);
            tick_result_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result request with no tick pending", $realtime);
                return;
            end
            want = pending_results.pop_front();
            if (got.duty_one !== want.duty_one || got.duty_two !== want.duty_two ||
                got.beat_pin !== want.beat_pin || got.status_pin !== want.status_pin ||
                got.slept !== want.slept || got.band !== want.band)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected duty %0d/%0d beat %0b status %0b slept %0b band %0d,",
                             $realtime, want.duty_one, want.duty_two, want.beat_pin,
                             want.status_pin, want.slept, want.band,
                             " got duty %0d/%0d beat %0b status %0b slept %0b band %0d",
                             got.duty_one, got.duty_two, got.beat_pin, got.status_pin,
                             got.slept, got.band);
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [blsc_pkg::APB_ADDR_W-1:0] paddr;
    logic [blsc_pkg::APB_DATA_W-1:0] pwdata;
    logic [blsc_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    int gap_pct   = 10;
    int stall_pct = 10;

    duty_predictor sb = new();

    blsc_sample_if sample_ch ();
    blsc_result_if result_ch ();

    battery_load_shedding_controller_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        tick_result_t got;
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
                sb.take_tick(sample_ch.sample_a, sample_ch.sample_b,
                             sample_ch.sample_c, sample_ch.sample_d);
            if (result_ch.valid && result_ch.ready)
            begin
                got.duty_one   = result_ch.duty_one;
                got.duty_two   = result_ch.duty_two;
                got.beat_pin   = result_ch.beat_pin;
                got.status_pin = result_ch.status_pin;
                got.slept      = result_ch.slept;
                got.band       = blsc_pkg::band_t'(result_ch.band);
                sb.match_result(got);
            end
        end
    end

    task automatic send_tick(input logic [7:0] a, input logic [7:0] b,
                             input logic [7:0] c, input logic [7:0] d);
        while ($urandom_range(99) < gap_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid    <= 1'b1;
        sample_ch.sample_a <= a;
        sample_ch.sample_b <= b;
        sample_ch.sample_c <= c;
        sample_ch.sample_d <= d;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    // Four readings scattered around a level, clamped to the converter range.
    task automatic send_near(input int level, input int spread);
        int v[4];
        foreach (v[i])
        begin
            v[i] = level + int'($urandom_range(0, 2 * spread)) - spread;
            if (v[i] < 0)
                v[i] = 0;
            else if (v[i] > 255)
                v[i] = 255;
        end
        send_tick(8'(v[0]), 8'(v[1]), 8'(v[2]), 8'(v[3]));
    endtask

    task automatic send_random_tick();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20)
            send_tick(8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)));
        else if (pick < 28)
            send_tick($urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(1) ? 8'hFF : 8'h00,
                      $urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(1) ? 8'hFF : 8'h00);
        else if (pick < 55)
            send_near(int'(sb.cfg.raise_level) + int'($urandom_range(1, 20)), 2);
        else if (pick < 70)
            send_near(int'(sb.cfg.raise_level) + int'($urandom_range(0, 6)) - 3, 1);
        else if (pick < 85)
            send_near(int'(sb.cfg.ease_level) + int'($urandom_range(0, 6)) - 3, 1);
        else
            send_near(int'(sb.cfg.sleep_level) + int'($urandom_range(0, 6)) - 3, 1);
    endtask

    task automatic run_phase(input int count);
        repeat (count)
            send_random_tick();
        sample_ch.valid <= 1'b0;
        // let the last request land in the predictor, then drain
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [blsc_pkg::REG_IDX_W-1:0] idx,
                             input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic apply_config(input blsc_pkg::cfg_t c);
        write_reg(blsc_pkg::REG_RAISE_LEVEL,   c.raise_level);
        write_reg(blsc_pkg::REG_EASE_LEVEL,    c.ease_level);
        write_reg(blsc_pkg::REG_SLEEP_LEVEL,   c.sleep_level);
        write_reg(blsc_pkg::REG_DUTY_LIMIT,    c.duty_limit);
        write_reg(blsc_pkg::REG_BEAT_PERIOD,   c.beat_period);
        write_reg(blsc_pkg::REG_SLOW_PERIOD,   c.slow_period);
        write_reg(blsc_pkg::REG_MEDIUM_PERIOD, c.medium_period);
        write_reg(blsc_pkg::REG_FAST_PERIOD,   c.fast_period);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic blsc_pkg::cfg_t random_cfg();
        blsc_pkg::cfg_t c;
        if ($urandom_range(4) == 0)
        begin
            // unordered levels
            c.sleep_level = 8'($urandom_range(255));
            c.ease_level  = 8'($urandom_range(255));
            c.raise_level = 8'($urandom_range(255));
        end
        else
        begin
            c.sleep_level = 8'($urandom_range(60, 140));
            c.ease_level  = c.sleep_level + 8'($urandom_range(30));
            c.raise_level = c.ease_level + 8'($urandom_range(30));
        end
        c.duty_limit    = 8'($urandom_range(1) ? $urandom_range(8) : $urandom_range(255));
        c.beat_period   = 8'($urandom_range(1, ($urandom_range(3) == 0) ? 255 : 8));
        c.slow_period   = 8'($urandom_range(1, ($urandom_range(3) == 0) ? 255 : 8));
        c.medium_period = 8'($urandom_range(1, ($urandom_range(3) == 0) ? 255 : 8));
        c.fast_period   = 8'($urandom_range(1, ($urandom_range(3) == 0) ? 255 : 8));
        return c;
    endfunction

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        sample_ch.valid    <= 1'b0;
        sample_ch.sample_a <= '0;
        sample_ch.sample_b <= '0;
        sample_ch.sample_c <= '0;
        sample_ch.sample_d <= '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks under reset levels: extremes, band edges, wrap on drop.
        send_tick(8'h00, 8'h00, 8'h00, 8'h00);
        send_tick(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_tick(8'hAA, 8'h55, 8'hAA, 8'h55);
        send_tick(8'h55, 8'hAA, 8'h55, 8'hAA);
        send_tick(8'hFF, 8'h00, 8'h00, 8'h00);
        send_near(122, 0);
        send_tick(8'd124, 8'd123, 8'd123, 8'd123);
        send_tick(8'd122, 8'd123, 8'd123, 8'd123);
        send_near(128, 0);
        send_near(129, 0);
        send_near(133, 0);
        send_near(134, 0);
        send_near(200, 0);
        send_near(200, 0);
        send_near(130, 0);
        send_near(125, 0);
        send_near(125, 0);
        send_near(125, 0);
        send_near(100, 0);
        send_near(125, 0);
        run_phase(150);

        // Every nonzero average raises: duties climb with no idling on either side.
        gap_pct   = 0;
        stall_pct = 0;
        apply_config('{raise_level: 8'd0, ease_level: 8'd0, sleep_level: 8'd0,
                       duty_limit: 8'd255, beat_period: 8'd255, slow_period: 8'd255,
                       medium_period: 8'd255, fast_period: 8'd255});
        run_phase(150);
        gap_pct   = 10;
        stall_pct = 10;

        // Limit drops below the duties reached above.
        apply_config('{raise_level: 8'd100, ease_level: 8'd80, sleep_level: 8'd40,
                       duty_limit: 8'd3, beat_period: 8'd1, slow_period: 8'd2,
                       medium_period: 8'd3, fast_period: 8'd255});
        run_phase(125);

        apply_config('{raise_level: 8'd255, ease_level: 8'd255, sleep_level: 8'd255,
                       duty_limit: 8'd255, beat_period: 8'd1, slow_period: 8'd1,
                       medium_period: 8'd1, fast_period: 8'd1});
        run_phase(60);

        repeat (5)
        begin
            apply_config(random_cfg());
            run_phase(110);
        end

        repeat (8)
            @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
